// File: rtl/core/gmsbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gmsbf_pkg;
  localparam int GRID_MAX = 64;
  localparam int MAX_CAND = 10;
  localparam int STEP_LIMIT = 110;
  localparam int CELLS = GRID_MAX * GRID_MAX;
  localparam int AW = $clog2(CELLS);
  localparam int PW = AW + 1;
  localparam int CW = $clog2(GRID_MAX);
  localparam int SW = 7;
  localparam int KW = $clog2(MAX_CAND + 1);
  localparam int MW = MAX_CAND + 1;
  localparam int TW = 7;
  localparam int PKW = 4;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_WALL = 2'd1;
  localparam logic [1:0] KIND_CAND = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  localparam logic REG_GRID_SIZE = 1'b0;
  localparam logic REG_PICK = 1'b1;

  typedef struct packed {
    logic [1:0] cell_kind;
    logic last_cell;
  } in_item_t;

  typedef struct packed {
    logic [TW-1:0] fill_time;
    logic unreachable;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_MASK, ST_CLR, ST_CLRD, ST_SEED, ST_DIV, ST_SEEDW,
    ST_LEVEL, ST_POP, ST_POPW, ST_NB, ST_NBI, ST_NBR, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic srch_init;
    logic mask_next;
    logic clr_start;
    logic clr_step;
    logic seed_next;
    logic div_start;
    logic div_step;
    logic seed_write;
    logic level_start;
    logic eval_ok;
    logic eval_fail;
    logic pop_read;
    logic pop_latch;
    logic nb_calc;
    logic nb_next;
    logic nb_write;
    logic swap;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic mask_end;
    logic mask_ok;
    logic clr_last;
    logic seed_end;
    logic seed_skip;
    logic div_done;
    logic t_limit;
    logic rem_zero;
    logic q_empty;
    logic head_end;
    logic nb_valid;
    logic d_last;
  } stat_t;

  function automatic logic [KW-1:0] popcnt(input logic [MAX_CAND-1:0] v);
    logic [KW-1:0] c;
    c = '0;
    for (int i = 0; i < MAX_CAND; i++) begin
      c = c + KW'(v[i]);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/grid_multi_source_bfs_best_fill.sv
`timescale 1ns / 1ps
`default_nettype none
// Grid flood search. Cells are loaded row-major on in_item, one item per cycle while
// busy is low; start with busy low accepts an item. The item with last_cell set starts
// the search and busy stays high until it ends. Every choice of the configured number
// of candidate cells is flooded in turn; out_valid pulses for one cycle with the least
// fill time or the unreachable flag, and the receiver cannot stall it.
// Each choice sweeps the visited map and grid memory to clear visits and count non-wall
// cells, skips each listed candidate that is not used, finds each chosen source's row
// by repeated subtraction, then per frontier cell reads and latches it, checks each
// direction against the grid edge and tests each neighbour, and swaps queues per level.
// The mask scan steps through every subset of the candidate list. out_valid is
// registered from the done state that follows the scan, and a new item may be
// accepted in the cycle out_valid is high. grid_size and sources_to_pick must be
// written over the APB-style port only while idle; the block does not enforce this.
// Reset returns to idle with no candidates listed and the load position at zero.
module grid_multi_source_bfs_best_fill
  import gmsbf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [SW-1:0]  grid_size_r;
  logic [PKW-1:0] pick_r;
  cmd_t           cmd;
  stat_t          stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= SW'(GRID_MAX);
      pick_r <= PKW'(1);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_GRID_SIZE) grid_size_r <= pwdata[SW-1:0];
      else pick_r <= pwdata[PKW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_PICK) ? {{(32-PKW){1'b0}}, pick_r} :
                                           {{(32-SW){1'b0}}, grid_size_r};

  gmsbf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_item.last_cell),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  gmsbf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .grid_size (grid_size_r),
    .pick_cfg  (pick_r),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );
endmodule
`default_nettype wire

// File: rtl/core/gmsbf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gmsbf_ctrl
  import gmsbf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire logic  in_last,
  input  wire stat_t stat,
  output logic       busy,
  output cmd_t       cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start && in_last) state_nxt = ST_INIT;
      ST_INIT: state_nxt = ST_MASK;
      ST_MASK: begin
        if (stat.mask_end) state_nxt = ST_DONE;
        else if (stat.mask_ok) state_nxt = ST_CLR;
      end
      ST_CLR: if (stat.clr_last) state_nxt = ST_CLRD;
      ST_CLRD: state_nxt = ST_SEED;
      ST_SEED: begin
        if (stat.seed_end) state_nxt = ST_LEVEL;
        else if (!stat.seed_skip) state_nxt = ST_DIV;
      end
      ST_DIV: if (stat.div_done) state_nxt = ST_SEEDW;
      ST_SEEDW: state_nxt = ST_SEED;
      ST_LEVEL: begin
        if (stat.t_limit || stat.rem_zero || stat.q_empty) state_nxt = ST_MASK;
        else state_nxt = ST_POP;
      end
      ST_POP: begin
        if (stat.head_end) state_nxt = ST_LEVEL;
        else state_nxt = ST_POPW;
      end
      ST_POPW: state_nxt = ST_NB;
      ST_NB: begin
        if (stat.nb_valid) state_nxt = ST_NBI;
        else if (stat.d_last) state_nxt = ST_POP;
      end
      ST_NBI: state_nxt = ST_NBR;
      ST_NBR: begin
        if (stat.d_last) state_nxt = ST_POP;
        else state_nxt = ST_NB;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: cmd.load = start;
      ST_INIT: cmd.srch_init = 1'b1;
      ST_MASK: begin
        if (!stat.mask_end) begin
          if (stat.mask_ok) cmd.clr_start = 1'b1;
          else cmd.mask_next = 1'b1;
        end
      end
      ST_CLR: cmd.clr_step = 1'b1;
      ST_SEED: begin
        if (!stat.seed_end) begin
          if (stat.seed_skip) cmd.seed_next = 1'b1;
          else cmd.div_start = 1'b1;
        end
      end
      ST_DIV: cmd.div_step = !stat.div_done;
      ST_SEEDW: cmd.seed_write = 1'b1;
      ST_LEVEL: begin
        if (stat.t_limit) cmd.eval_fail = 1'b1;
        else if (stat.rem_zero) cmd.eval_ok = 1'b1;
        else if (stat.q_empty) cmd.eval_fail = 1'b1;
        else cmd.level_start = 1'b1;
      end
      ST_POP: begin
        if (stat.head_end) cmd.swap = 1'b1;
        else cmd.pop_read = 1'b1;
      end
      ST_POPW: cmd.pop_latch = 1'b1;
      ST_NB: begin
        if (stat.nb_valid) cmd.nb_calc = 1'b1;
        else cmd.nb_next = 1'b1;
      end
      ST_NBR: begin
        cmd.nb_write = 1'b1;
        cmd.nb_next = 1'b1;
      end
      ST_DONE: cmd.done = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/core/gmsbf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module gmsbf_dp
  import gmsbf_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire in_item_t       in_item,
  input  wire logic [SW-1:0]  grid_size,
  input  wire logic [PKW-1:0] pick_cfg,
  input  wire cmd_t           cmd,
  output stat_t               stat,
  output logic                out_valid,
  output out_item_t           out_item
);
  logic [1:0]    grid_mem [CELLS];
  logic          vis_mem [CELLS];
  logic [AW-1:0] q0_mem [CELLS];
  logic [AW-1:0] q1_mem [CELLS];
  logic [AW-1:0] cand_r [MAX_CAND];

  logic [1:0]    grid_q_r;
  logic          vis_q_r;
  logic [AW-1:0] q0_q_r, q1_q_r;
  logic [PW-1:0] load_pos_r, clr_idx_r, rem_r, tail_r, ntail_r, head_r;
  logic [KW-1:0] cand_cnt_r, k_r;
  logic [MW-1:0] m_r;
  logic [TW-1:0] t_r, best_r;
  logic          best_valid_r, sel_r, cnt_v_r, out_valid_r;
  out_item_t     out_item_r;
  logic [CW-1:0] div_row_r, cur_r_r, cur_c_r, nr_r, nc_r;
  logic [AW-1:0] div_c_r, idx_r;
  logic [1:0]    d_r;

  logic [SW-1:0] side;
  logic [PW-1:0] area;
  logic [KW-1:0] pick_eff;
  logic [AW-1:0] cand_p;
  logic          nb_ok;
  logic [CW-1:0] nr, nc;
  logic [2*SW-1:0] nb_prod;
  logic          nb_wr_en, grid_we, vis_we, vis_wd, q0_we, q1_we;
  logic [AW-1:0] grid_ra, vis_wa, q_wa, q_wd;

  assign side = (grid_size == '0) ? SW'(1) :
                (grid_size > SW'(GRID_MAX)) ? SW'(GRID_MAX) : grid_size;
  assign area = PW'(side) * PW'(side);
  assign pick_eff = (KW'(pick_cfg) > cand_cnt_r) ? cand_cnt_r : KW'(pick_cfg);
  assign cand_p = cand_r[k_r];

  always_comb begin
    nr = cur_r_r;
    nc = cur_c_r;
    nb_ok = 1'b0;
    case (d_r)
      2'd0: begin
        nb_ok = ({1'b0, cur_r_r} + SW'(1)) < side;
        nr = cur_r_r + CW'(1);
      end
      2'd1: begin
        nb_ok = ({1'b0, cur_c_r} + SW'(1)) < side;
        nc = cur_c_r + CW'(1);
      end
      2'd2: begin
        nb_ok = (cur_r_r != '0);
        nr = cur_r_r - CW'(1);
      end
      2'd3: begin
        nb_ok = (cur_c_r != '0);
        nc = cur_c_r - CW'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign nb_prod = {1'b0, nr} * side;

  assign stat.mask_end = (m_r == (MW'(1) << cand_cnt_r));
  assign stat.mask_ok = (popcnt(m_r[MAX_CAND-1:0]) == pick_eff);
  assign stat.clr_last = (clr_idx_r == area - PW'(1));
  assign stat.seed_end = (k_r == cand_cnt_r);
  assign stat.seed_skip = !m_r[k_r] || ({1'b0, cand_p} >= area);
  assign stat.div_done = (div_c_r < AW'(side));
  assign stat.t_limit = (t_r == TW'(STEP_LIMIT));
  assign stat.rem_zero = (rem_r == '0);
  assign stat.q_empty = (tail_r == '0);
  assign stat.head_end = (head_r == tail_r);
  assign stat.nb_valid = nb_ok;
  assign stat.d_last = (d_r == 2'd3);

  assign nb_wr_en = cmd.nb_write && !vis_q_r && (grid_q_r != KIND_WALL);
  assign grid_we = cmd.load && (load_pos_r < area);
  assign grid_ra = cmd.clr_step ? clr_idx_r[AW-1:0] : idx_r;
  assign vis_we = cmd.clr_step || cmd.seed_write || nb_wr_en;
  assign vis_wd = !cmd.clr_step;
  assign vis_wa = cmd.clr_step ? clr_idx_r[AW-1:0] :
                  cmd.seed_write ? cand_p : idx_r;
  assign q_wa = cmd.seed_write ? tail_r[AW-1:0] : ntail_r[AW-1:0];
  assign q_wd = cmd.seed_write ? {div_row_r, div_c_r[CW-1:0]} : {nr_r, nc_r};
  assign q0_we = (cmd.seed_write && !sel_r) || (nb_wr_en && sel_r);
  assign q1_we = (cmd.seed_write && sel_r) || (nb_wr_en && !sel_r);

  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[load_pos_r[AW-1:0]] <= in_item.cell_kind;
    grid_q_r <= grid_mem[grid_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q_r <= vis_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (q0_we) q0_mem[q_wa] <= q_wd;
    q0_q_r <= q0_mem[head_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q1_we) q1_mem[q_wa] <= q_wd;
    q1_q_r <= q1_mem[head_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && grid_we && (in_item.cell_kind == KIND_CAND) &&
        (cand_cnt_r < KW'(MAX_CAND))) begin
      cand_r[cand_cnt_r] <= load_pos_r[AW-1:0];
    end
    if (cmd.div_start) begin
      div_row_r <= '0;
      div_c_r <= cand_p;
    end
    if (cmd.div_step) begin
      div_row_r <= div_row_r + CW'(1);
      div_c_r <= div_c_r - AW'(side);
    end
    if (cmd.pop_latch) begin
      cur_r_r <= sel_r ? q1_q_r[AW-1:CW] : q0_q_r[AW-1:CW];
      cur_c_r <= sel_r ? q1_q_r[CW-1:0] : q0_q_r[CW-1:0];
    end
    if (cmd.nb_calc) begin
      nr_r <= nr;
      nc_r <= nc;
      idx_r <= AW'(nb_prod + (2*SW)'(nc));
    end
    out_item_r.fill_time <= best_valid_r ? best_r : '0;
    out_item_r.unreachable <= !best_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
      cand_cnt_r <= '0;
      m_r <= '0;
      best_r <= '0;
      best_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      clr_idx_r <= '0;
      rem_r <= '0;
      tail_r <= '0;
      ntail_r <= '0;
      head_r <= '0;
      k_r <= '0;
      t_r <= '0;
      sel_r <= 1'b0;
      cnt_v_r <= 1'b0;
      d_r <= '0;
    end else begin
      out_valid_r <= cmd.done;
      cnt_v_r <= cmd.clr_step;
      if (cmd.load) begin
        if (grid_we) begin
          load_pos_r <= load_pos_r + PW'(1);
          if ((in_item.cell_kind == KIND_CAND) && (cand_cnt_r < KW'(MAX_CAND))) begin
            cand_cnt_r <= cand_cnt_r + KW'(1);
          end
        end
      end
      if (cmd.done) begin
        load_pos_r <= '0;
        cand_cnt_r <= '0;
      end
      if (cmd.srch_init) begin
        m_r <= '0;
        best_r <= '0;
        best_valid_r <= 1'b0;
      end
      if (cmd.mask_next || cmd.eval_fail) m_r <= m_r + MW'(1);
      if (cmd.eval_ok) begin
        m_r <= m_r + MW'(1);
        if (!best_valid_r || (t_r < best_r)) begin
          best_r <= t_r;
          best_valid_r <= 1'b1;
        end
      end
      if (cmd.clr_start) begin
        clr_idx_r <= '0;
        rem_r <= '0;
        t_r <= '0;
        sel_r <= 1'b0;
        tail_r <= '0;
        head_r <= '0;
        k_r <= '0;
      end
      if (cmd.clr_step) clr_idx_r <= clr_idx_r + PW'(1);
      if (cnt_v_r && (grid_q_r != KIND_WALL)) rem_r <= rem_r + PW'(1);
      if (cmd.seed_next) k_r <= k_r + KW'(1);
      if (cmd.seed_write) begin
        k_r <= k_r + KW'(1);
        rem_r <= rem_r - PW'(1);
        tail_r <= tail_r + PW'(1);
      end
      if (cmd.level_start) begin
        head_r <= '0;
        ntail_r <= '0;
      end
      if (cmd.pop_read) head_r <= head_r + PW'(1);
      if (cmd.pop_latch) d_r <= '0;
      if (cmd.nb_next) d_r <= d_r + 2'd1;
      if (nb_wr_en) begin
        rem_r <= rem_r - PW'(1);
        ntail_r <= ntail_r + PW'(1);
      end
      if (cmd.swap) begin
        sel_r <= !sel_r;
        tail_r <= ntail_r;
        head_r <= '0;
        t_r <= t_r + TW'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r <= PW'(CELLS)) && (ntail_r <= PW'(CELLS)))
    else $error("queue count beyond grid capacity");
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("queue read passed its write point");
  a_rem_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (nb_wr_en || cmd.seed_write) |-> (rem_r != '0))
    else $error("remaining cell count would underflow");
  a_seed_row: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seed_write |-> (div_c_r < AW'(side)))
    else $error("seed column not reduced below grid side");
endmodule
`default_nettype wire
